// ===== rtl/ccb_pkg.sv =====
`default_nettype none

package ccb_pkg;

    // step_time after reset, Q0.16 seconds
    localparam logic [15:0] STEP_TIME_RESET = 16'd1092;

    // stream payload widths
    localparam int IN_W  = 176;
    localparam int OUT_W = 64;

    // center-line projection divider: |k*d| / |d|^2
    localparam int N1_W = 50;
    localparam int D1_W = 32;
    localparam int Q1_W = 17;

    // mass weighting divider: 2*m*|w| / (m1+m2)
    localparam int N2_W = 34;
    localparam int D2_W = 17;
    localparam int Q2_W = 18;

    // register stages from input transfer to output register
    localparam int PRE_STAGES = 5;
    localparam int LAT        = PRE_STAGES + Q1_W + 1 + Q2_W + 1;

    localparam logic signed [35:0] VEL_MAX = 36'sd32767;
    localparam logic signed [35:0] VEL_MIN = -36'sd32768;

    // fields that ride along the front stages unchanged
    typedef struct packed {
        logic               kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic [15:0]        m1;
        logic [15:0]        m2;
    } t_pass;

    // sideband carried beside the dividers
    typedef struct packed {
        logic               hit;
        logic               xchg;
        logic               sgn_x;
        logic               sgn_y;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic [15:0]        m1;
        logic [15:0]        m2;
        logic [16:0]        ms;
    } t_side;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > VEL_MAX) begin
            r = 16'sh7fff;
        end else if (v < VEL_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ccb_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees i_num < i_den * 2**QW.
module ccb_div #(
    parameter int NW = 50,
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [CW-1:0] shd;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (j == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
        end

        // trial subtract of the divisor at this bit weight
        assign shd = CW'(den_in) << (QW - 1 - j);
        assign ge  = CW'(rem_in) >= shd;

        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            if (ge) begin
                n_rem            = NW'(CW'(rem_in) - shd);
                n_quo[QW-1-j]    = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_den[j] <= den_in;
                r_quo[j] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

// ===== rtl/circle_collision_test_and_bounce_unit.sv =====
// Circle collision test and bounce, one pair test per transfer.
// Input stream s_axis: one pair (ball against ball, or ball against wall);
// tuser is the kind, tdata packs the position, velocity, size and mass fields.
// Output stream m_axis: one result per input; tuser is hit, tdata packs the
// new ball and second-object velocities, saturated Q8.8.
// i_cfg_we/i_cfg_data write step_time; write it only while the unit is empty.
// A pair passes 42 register stages: capture, four arithmetic stages, a 17-stage
// divider for the center-line projection, one multiply stage, an 18-stage
// divider for the mass weighting and the output register.
// Throughput is one pair per cycle unless m_axis stalls. The whole pipeline
// advances together; s_axis_tready is high whenever the output register is empty
// or being taken, so a stalled receiver holds every stage in place and nothing is lost.
// Reset (synchronous, active low) empties the pipeline and loads step_time
// with 1092 (about 1/60 s).
`default_nettype none

module circle_collision_test_and_bounce_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [15:0]               i_cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // rel_x, rel_y, ball_vel_x, ball_vel_y, second_x, second_y, ball_radius,
    // second_size, wall_length, ball_mass, second_mass, 3 pad bits
    input  wire logic [ccb_pkg::IN_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic                      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // new_ball_vel_x, new_ball_vel_y, new_second_vel_x, new_second_vel_y
    output logic [ccb_pkg::OUT_W-1:0]      m_axis_tdata,
    // hit
    output logic                           m_axis_tuser
);

    localparam int LAT = ccb_pkg::LAT;

    logic                en;
    logic [LAT-1:0]      r_vld;
    logic [15:0]         r_step_time;

    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    // step_time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= ccb_pkg::STEP_TIME_RESET;
        end else if (i_cfg_we) begin
            r_step_time <= i_cfg_data;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: capture ----------------
    ccb_pkg::t_pass r1_p;
    logic [14:0]    r1_r1, r1_r2, r1_len;
    logic [15:0]    r1_st;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p.kind <= s_axis_tuser;
            r1_p.dx   <= s_axis_tdata[15:0];
            r1_p.dy   <= s_axis_tdata[31:16];
            r1_p.ux   <= s_axis_tdata[47:32];
            r1_p.uy   <= s_axis_tdata[63:48];
            r1_p.sx   <= s_axis_tdata[79:64];
            r1_p.sy   <= s_axis_tdata[95:80];
            r1_r1     <= s_axis_tdata[110:96];
            r1_r2     <= s_axis_tdata[125:111];
            r1_len    <= s_axis_tdata[140:126];
            r1_p.m1   <= s_axis_tdata[156:141];
            r1_p.m2   <= s_axis_tdata[172:157];
            r1_st     <= r_step_time;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [16:0] n2_rvx, n2_rvy;
    logic signed [33:0] n2_tx, n2_ty;
    logic signed [32:0] n2_ax, n2_ay;
    logic signed [31:0] n2_xx, n2_yy, n2_sxp, n2_syp, n2_lx, n2_ly, n2_vx, n2_vy;

    assign n2_rvx = 17'(r1_p.ux) - 17'(r1_p.sx);
    assign n2_rvy = 17'(r1_p.uy) - 17'(r1_p.sy);
    assign n2_tx  = n2_rvx * $signed({1'b0, r1_st});
    assign n2_ty  = n2_rvy * $signed({1'b0, r1_st});
    assign n2_ax  = n2_rvx * r1_p.dx;
    assign n2_ay  = n2_rvy * r1_p.dy;
    assign n2_xx  = r1_p.dx * r1_p.dx;
    assign n2_yy  = r1_p.dy * r1_p.dy;
    assign n2_sxp = r1_p.dx * r1_p.sx;
    assign n2_syp = r1_p.dy * r1_p.sy;
    assign n2_lx  = r1_p.dy * r1_p.sx;
    assign n2_ly  = r1_p.dx * r1_p.sy;
    assign n2_vx  = r1_p.ux * r1_p.sx;
    assign n2_vy  = r1_p.uy * r1_p.sy;

    ccb_pkg::t_pass     r2_p;
    logic signed [33:0] r2_tx, r2_ty;
    logic signed [32:0] r2_ax, r2_ay;
    logic signed [31:0] r2_xx, r2_yy, r2_sxp, r2_syp, r2_lx, r2_ly, r2_vx, r2_vy;
    logic [15:0]        r2_rr;
    logic [16:0]        r2_band;
    logic [14:0]        r2_len;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p    <= r1_p;
            r2_tx   <= n2_tx;
            r2_ty   <= n2_ty;
            r2_ax   <= n2_ax;
            r2_ay   <= n2_ay;
            r2_xx   <= n2_xx;
            r2_yy   <= n2_yy;
            r2_sxp  <= n2_sxp;
            r2_syp  <= n2_syp;
            r2_lx   <= n2_lx;
            r2_ly   <= n2_ly;
            r2_vx   <= n2_vx;
            r2_vy   <= n2_vy;
            r2_rr   <= 16'(r1_r1) + 16'(r1_r2);
            r2_band <= 17'({r1_r1, 1'b0}) + 17'(r1_r2);
            r2_len  <= r1_len;
        end
    end

    // ---------------- stage 3: sums ----------------
    logic signed [33:0] n3_txa, n3_tya;
    logic signed [17:0] n3_ex, n3_ey;
    logic signed [33:0] n3_a;
    logic [31:0]        n3_dd;
    logic signed [32:0] n3_s, n3_along, n3_vn;

    // predicted offset, step scaling truncated toward zero
    assign n3_txa   = r2_tx + (r2_tx[33] ? 34'sd65535 : 34'sd0);
    assign n3_tya   = r2_ty + (r2_ty[33] ? 34'sd65535 : 34'sd0);
    assign n3_ex    = 18'(r2_p.dx) - $signed(n3_txa[33:16]);
    assign n3_ey    = 18'(r2_p.dy) - $signed(n3_tya[33:16]);
    assign n3_a     = 34'(r2_ax) + 34'(r2_ay);
    assign n3_dd    = r2_xx[31:0] + r2_yy[31:0];
    assign n3_s     = 33'(r2_sxp) + 33'(r2_syp);
    assign n3_along = 33'(r2_lx) - 33'(r2_ly);
    assign n3_vn    = 33'(r2_vx) + 33'(r2_vy);

    ccb_pkg::t_pass     r3_p;
    logic signed [17:0] r3_ex, r3_ey;
    logic signed [33:0] r3_a;
    logic [31:0]        r3_dd;
    logic signed [32:0] r3_s, r3_along, r3_vn;
    logic [15:0]        r3_rr;
    logic [23:0]        r3_band;
    logic [21:0]        r3_lenb;
    logic [16:0]        r3_ms;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p     <= r2_p;
            r3_ex    <= n3_ex;
            r3_ey    <= n3_ey;
            r3_a     <= n3_a;
            r3_dd    <= n3_dd;
            r3_s     <= n3_s;
            r3_along <= n3_along;
            r3_vn    <= n3_vn;
            r3_rr    <= r2_rr;
            r3_band  <= {r2_band, 7'd0};
            r3_lenb  <= {r2_len, 7'd0};
            r3_ms    <= 17'(r2_p.m1) + 17'(r2_p.m2);
        end
    end

    // ---------------- stage 4: squares, wall test, split products ----------------
    logic signed [35:0] n4_ex2, n4_ey2;
    logic [31:0]        n4_rr2;
    logic signed [33:0] n4_k;
    logic signed [33:0] n4_pkh_x, n4_pkh_y;
    logic signed [32:0] n4_pkl_x, n4_pkl_y;
    logic [32:0]        n4_sabs, n4_labs;
    logic               n4_toward, n4_wall_hit;
    logic signed [32:0] n4_pvh_x, n4_pvh_y, n4_pvl_x, n4_pvl_y;

    assign n4_ex2 = r3_ex * r3_ex;
    assign n4_ey2 = r3_ey * r3_ey;
    assign n4_rr2 = r3_rr * r3_rr;

    // k = (u2 - u1).d, split into 18-bit high and 16-bit low halves
    assign n4_k     = -r3_a;
    assign n4_pkh_x = $signed(n4_k[33:16]) * r3_p.dx;
    assign n4_pkh_y = $signed(n4_k[33:16]) * r3_p.dy;
    assign n4_pkl_x = $signed({1'b0, n4_k[15:0]}) * r3_p.dx;
    assign n4_pkl_y = $signed({1'b0, n4_k[15:0]}) * r3_p.dy;

    // wall bands and approach
    assign n4_sabs     = r3_s[32] ? 33'(-r3_s) : 33'(r3_s);
    assign n4_labs     = r3_along[32] ? 33'(-r3_along) : 33'(r3_along);
    assign n4_toward   = r3_s[32] ? r3_vn[32] : (!r3_vn[32] && (r3_vn != '0));
    assign n4_wall_hit = (n4_sabs < 33'(r3_band)) && (n4_labs < 33'(r3_lenb)) && n4_toward;

    // vn * n, vn split into 17-bit high and 16-bit low halves
    assign n4_pvh_x = $signed(r3_vn[32:16]) * r3_p.sx;
    assign n4_pvh_y = $signed(r3_vn[32:16]) * r3_p.sy;
    assign n4_pvl_x = $signed({1'b0, r3_vn[15:0]}) * r3_p.sx;
    assign n4_pvl_y = $signed({1'b0, r3_vn[15:0]}) * r3_p.sy;

    ccb_pkg::t_pass     r4_p;
    logic [35:0]        r4_ex2, r4_ey2;
    logic [31:0]        r4_rr2;
    logic               r4_apos, r4_wall_hit;
    logic signed [33:0] r4_pkh_x, r4_pkh_y;
    logic signed [32:0] r4_pkl_x, r4_pkl_y;
    logic signed [32:0] r4_pvh_x, r4_pvh_y, r4_pvl_x, r4_pvl_y;
    logic [31:0]        r4_dd;
    logic [16:0]        r4_ms;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p        <= r3_p;
            r4_ex2      <= n4_ex2;
            r4_ey2      <= n4_ey2;
            r4_rr2      <= n4_rr2;
            r4_apos     <= !r3_a[33] && (r3_a != '0);
            r4_wall_hit <= n4_wall_hit;
            r4_pkh_x    <= n4_pkh_x;
            r4_pkh_y    <= n4_pkh_y;
            r4_pkl_x    <= n4_pkl_x;
            r4_pkl_y    <= n4_pkl_y;
            r4_pvh_x    <= n4_pvh_x;
            r4_pvh_y    <= n4_pvh_y;
            r4_pvl_x    <= n4_pvl_x;
            r4_pvl_y    <= n4_pvl_y;
            r4_dd       <= r3_dd;
            r4_ms       <= r3_ms;
        end
    end

    // ---------------- stage 5: hit decision, wall response, divider operands ----------------
    logic [36:0]        n5_sq;
    logic               n5_ball_hit;
    logic signed [49:0] n5_nx, n5_ny;
    logic signed [48:0] n5_pvx, n5_pvy, n5_pvxa, n5_pvya;
    logic signed [34:0] n5_wbx, n5_wby;
    logic               n5_wall;
    ccb_pkg::t_side     n5_side;

    assign n5_sq       = 37'(r4_ex2) + 37'(r4_ey2);
    assign n5_ball_hit = (n5_sq < 37'(r4_rr2)) && r4_apos;

    assign n5_nx = $signed({r4_pkh_x, 16'd0}) + 50'(r4_pkl_x);
    assign n5_ny = $signed({r4_pkh_y, 16'd0}) + 50'(r4_pkl_y);

    // reflection: u - 2*vn*n / 2^16, truncated toward zero
    assign n5_pvx  = $signed({r4_pvh_x[32:0], 16'd0}) + 49'(r4_pvl_x);
    assign n5_pvy  = $signed({r4_pvh_y[32:0], 16'd0}) + 49'(r4_pvl_y);
    assign n5_pvxa = n5_pvx + (n5_pvx[48] ? 49'sd32767 : 49'sd0);
    assign n5_pvya = n5_pvy + (n5_pvy[48] ? 49'sd32767 : 49'sd0);
    assign n5_wbx  = 35'(r4_p.ux) - 35'($signed(n5_pvxa[48:15]));
    assign n5_wby  = 35'(r4_p.uy) - 35'($signed(n5_pvya[48:15]));
    assign n5_wall = r4_p.kind && r4_wall_hit;

    always_comb begin
        n5_side.hit   = r4_p.kind ? r4_wall_hit : n5_ball_hit;
        n5_side.xchg  = !r4_p.kind && n5_ball_hit && (r4_dd != '0) && (r4_ms != '0);
        n5_side.sgn_x = n5_nx[49];
        n5_side.sgn_y = n5_ny[49];
        n5_side.ux    = r4_p.ux;
        n5_side.uy    = r4_p.uy;
        n5_side.sx    = r4_p.sx;
        n5_side.sy    = r4_p.sy;
        n5_side.bx    = n5_wall ? ccb_pkg::sat16(36'(n5_wbx)) : r4_p.ux;
        n5_side.by    = n5_wall ? ccb_pkg::sat16(36'(n5_wby)) : r4_p.uy;
        n5_side.m1    = r4_p.m1;
        n5_side.m2    = r4_p.m2;
        n5_side.ms    = r4_ms;
    end

    logic [ccb_pkg::N1_W-1:0] r5_magx, r5_magy;
    logic [ccb_pkg::D1_W-1:0] r5_dd;
    ccb_pkg::t_side           r5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_magx <= n5_nx[49] ? 50'(-n5_nx) : 50'(n5_nx);
            r5_magy <= n5_ny[49] ? 50'(-n5_ny) : 50'(n5_ny);
            r5_dd   <= r4_dd;
            r5_side <= n5_side;
        end
    end

    // ---------------- projection divider ----------------
    logic [ccb_pkg::Q1_W-1:0] w_q1x, w_q1y;
    ccb_pkg::t_side           r_sd1 [0:ccb_pkg::Q1_W-1];

    ccb_div #(.NW(ccb_pkg::N1_W), .DW(ccb_pkg::D1_W), .QW(ccb_pkg::Q1_W)) u_div1x (
        .i_clk (i_clk), .i_en (en), .i_num (r5_magx), .i_den (r5_dd), .o_quo (w_q1x)
    );
    ccb_div #(.NW(ccb_pkg::N1_W), .DW(ccb_pkg::D1_W), .QW(ccb_pkg::Q1_W)) u_div1y (
        .i_clk (i_clk), .i_en (en), .i_num (r5_magy), .i_den (r5_dd), .o_quo (w_q1y)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1[0] <= r5_side;
            for (int i = 1; i < ccb_pkg::Q1_W; i++) begin
                r_sd1[i] <= r_sd1[i-1];
            end
        end
    end

    // ---------------- stage 6: mass weighting products ----------------
    ccb_pkg::t_side           w_s6;
    logic [32:0]              n6_bx, n6_by, n6_sx, n6_sy;
    logic [ccb_pkg::N2_W-1:0] r6_bx, r6_by, r6_sx, r6_sy;
    ccb_pkg::t_side           r6_side;

    assign w_s6  = r_sd1[ccb_pkg::Q1_W-1];
    assign n6_bx = w_s6.m2 * w_q1x;
    assign n6_by = w_s6.m2 * w_q1y;
    assign n6_sx = w_s6.m1 * w_q1x;
    assign n6_sy = w_s6.m1 * w_q1y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_bx   <= {n6_bx, 1'b0};
            r6_by   <= {n6_by, 1'b0};
            r6_sx   <= {n6_sx, 1'b0};
            r6_sy   <= {n6_sy, 1'b0};
            r6_side <= w_s6;
        end
    end

    // ---------------- mass divider ----------------
    logic [ccb_pkg::Q2_W-1:0] w_q2bx, w_q2by, w_q2sx, w_q2sy;
    ccb_pkg::t_side           r_sd2 [0:ccb_pkg::Q2_W-1];

    ccb_div #(.NW(ccb_pkg::N2_W), .DW(ccb_pkg::D2_W), .QW(ccb_pkg::Q2_W)) u_div2bx (
        .i_clk (i_clk), .i_en (en), .i_num (r6_bx), .i_den (r6_side.ms), .o_quo (w_q2bx)
    );
    ccb_div #(.NW(ccb_pkg::N2_W), .DW(ccb_pkg::D2_W), .QW(ccb_pkg::Q2_W)) u_div2by (
        .i_clk (i_clk), .i_en (en), .i_num (r6_by), .i_den (r6_side.ms), .o_quo (w_q2by)
    );
    ccb_div #(.NW(ccb_pkg::N2_W), .DW(ccb_pkg::D2_W), .QW(ccb_pkg::Q2_W)) u_div2sx (
        .i_clk (i_clk), .i_en (en), .i_num (r6_sx), .i_den (r6_side.ms), .o_quo (w_q2sx)
    );
    ccb_div #(.NW(ccb_pkg::N2_W), .DW(ccb_pkg::D2_W), .QW(ccb_pkg::Q2_W)) u_div2sy (
        .i_clk (i_clk), .i_en (en), .i_num (r6_sy), .i_den (r6_side.ms), .o_quo (w_q2sy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd2[0] <= r6_side;
            for (int i = 1; i < ccb_pkg::Q2_W; i++) begin
                r_sd2[i] <= r_sd2[i-1];
            end
        end
    end

    // ---------------- stage 7: apply signs, saturate, output register ----------------
    ccb_pkg::t_side     w_s7;
    logic signed [18:0] n7_dbx, n7_dby, n7_dsx, n7_dsy;
    logic signed [19:0] n7_bx, n7_by, n7_sx, n7_sy;
    logic signed [15:0] n7_obx, n7_oby, n7_osx, n7_osy;

    assign w_s7   = r_sd2[ccb_pkg::Q2_W-1];
    assign n7_dbx = w_s7.sgn_x ? -$signed({1'b0, w_q2bx}) : $signed({1'b0, w_q2bx});
    assign n7_dby = w_s7.sgn_y ? -$signed({1'b0, w_q2by}) : $signed({1'b0, w_q2by});
    assign n7_dsx = w_s7.sgn_x ? -$signed({1'b0, w_q2sx}) : $signed({1'b0, w_q2sx});
    assign n7_dsy = w_s7.sgn_y ? -$signed({1'b0, w_q2sy}) : $signed({1'b0, w_q2sy});
    assign n7_bx  = 20'(w_s7.ux) + 20'(n7_dbx);
    assign n7_by  = 20'(w_s7.uy) + 20'(n7_dby);
    assign n7_sx  = 20'(w_s7.sx) - 20'(n7_dsx);
    assign n7_sy  = 20'(w_s7.sy) - 20'(n7_dsy);

    assign n7_obx = w_s7.xchg ? ccb_pkg::sat16(36'(n7_bx)) : w_s7.bx;
    assign n7_oby = w_s7.xchg ? ccb_pkg::sat16(36'(n7_by)) : w_s7.by;
    assign n7_osx = w_s7.xchg ? ccb_pkg::sat16(36'(n7_sx)) : w_s7.sx;
    assign n7_osy = w_s7.xchg ? ccb_pkg::sat16(36'(n7_sy)) : w_s7.sy;

    logic [ccb_pkg::OUT_W-1:0] r_out_data;
    logic                      r_out_hit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {n7_osy, n7_osx, n7_oby, n7_obx};
            r_out_hit  <= w_s7.hit;
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_hit;

endmodule

`default_nettype wire

// ===== rtl/ccb_checker.sv =====
`default_nettype none

module ccb_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [ccb_pkg::OUT_W-1:0] m_axis_tdata,
    input wire logic                     m_axis_tuser
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // input side moves exactly when the output register can make room
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("s_axis_tready does not follow the output register");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind circle_collision_test_and_bounce_unit ccb_checker u_ccb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
